@@ rtl/core/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the running statistics accumulator.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int COUNT_BITS = 20;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = COUNT_BITS + 1;
    localparam int SUM_W      = 36;
    localparam int SQ_W       = 52;
    localparam int MUL_W      = 73;
    localparam int DNUM_W     = 72;
    localparam int FRAC_W     = 16;
    localparam int NUM_W      = DNUM_W + 2 * FRAC_W;
    localparam int DEN_W      = 42;
    localparam int QUO_W      = 64;
    localparam int MEAN_W     = 32;
    localparam int VAR_W      = 47;
    localparam int DEV_W      = 31;
    localparam int STEP_W     = 7;
    localparam int MUL_STEPS  = SUM_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int SQRT_STEPS = QUO_W / 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1) << COUNT_BITS;

    typedef struct packed {
        logic        [CNT_W-1:0]    count;
        logic signed [SUM_W-1:0]    total;
        logic        [SQ_W-1:0]     sq_sum;
        logic signed [SAMPLE_W-1:0] lowest;
        logic signed [SAMPLE_W-1:0] highest;
    } rsa_snap_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_Q,
        ST_MUL_D,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DIV_MEAN,
        ST_DONE
    } rsa_state_t;

endpackage

@@ rtl/core/rsa_front.sv @@
// ----------------------------------------------------------------------------
// rsa_front
// Sample accumulators; pushes a snapshot of the statistics at each group end.
// ----------------------------------------------------------------------------
module rsa_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               take,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] sample,
    input  logic                               has_sample,
    input  logic                               group_end,
    output logic                               push,
    output rsa_pkg::rsa_snap_t                 push_data
);

    logic        [rsa_pkg::CNT_W-1:0]    count_reg, count_next;
    logic signed [rsa_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic        [rsa_pkg::SQ_W-1:0]     sq_reg, sq_next;
    logic signed [rsa_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic signed [rsa_pkg::SAMPLE_W-1:0] max_reg, max_next;
    logic                                seen_reg, seen_next;
    logic                                add;
    logic        [rsa_pkg::SAMPLE_W-1:0] mag;
    logic        [2*rsa_pkg::SAMPLE_W-1:0] square;

    always_comb begin
        add    = take && has_sample && (count_reg < rsa_pkg::COUNT_MAX);
        mag    = sample[rsa_pkg::SAMPLE_W-1] ? rsa_pkg::SAMPLE_W'(-sample)
                                             : rsa_pkg::SAMPLE_W'(sample);
        square = mag * mag;
        count_next = count_reg;
        sum_next   = sum_reg;
        sq_next    = sq_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        seen_next  = seen_reg;
        if (add) begin
            count_next = count_reg + rsa_pkg::CNT_W'(1);
            sum_next   = sum_reg + rsa_pkg::SUM_W'(sample);
            sq_next    = sq_reg + rsa_pkg::SQ_W'(square);
            seen_next  = 1'b1;
            if (!seen_reg) begin
                min_next = sample;
                max_next = sample;
            end else begin
                if (sample < min_reg) min_next = sample;
                if (sample > max_reg) max_next = sample;
            end
        end
        push              = take && group_end;
        push_data.count   = count_next;
        push_data.total   = sum_next;
        push_data.sq_sum  = sq_next;
        push_data.lowest  = min_next;
        push_data.highest = max_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            seen_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            sq_reg    <= sq_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            seen_reg  <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rsa_pkg::COUNT_MAX) else $error("count past limit");
    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_reg <= max_reg)) else $error("min above max");
`endif

endmodule

@@ rtl/core/rsa_queue.sv @@
// ----------------------------------------------------------------------------
// rsa_queue
// Two-entry snapshot queue between the accumulators and the result engine.
// ----------------------------------------------------------------------------
module rsa_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  rsa_pkg::rsa_snap_t push_data,
    input  logic               pop,
    output rsa_pkg::rsa_snap_t pop_data,
    output logic               full,
    output logic               empty
);

    rsa_pkg::rsa_snap_t mem_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push |-> !full) and (pop |-> !empty)) else $error("queue misuse");
`endif

endmodule

@@ rtl/core/rsa_back.sv @@
// ----------------------------------------------------------------------------
// rsa_back
// Result engine: shift-add multiplier, restoring divider, bit-pair square
// root, sequenced per snapshot, with a registered result word.
// ----------------------------------------------------------------------------
module rsa_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_empty,
    input  rsa_pkg::rsa_snap_t                  q_data,
    output logic                                pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [rsa_pkg::CNT_W-1:0]    m_count,
    output logic signed [rsa_pkg::SUM_W-1:0]    m_total,
    output logic signed [rsa_pkg::SAMPLE_W-1:0] m_lowest,
    output logic signed [rsa_pkg::SAMPLE_W-1:0] m_highest,
    output logic signed [rsa_pkg::MEAN_W-1:0]   m_mean_q16,
    output logic        [rsa_pkg::VAR_W-1:0]    m_variance_q16,
    output logic        [rsa_pkg::DEV_W-1:0]    m_deviation_q16
);

    rsa_pkg::rsa_state_t state_reg, state_next;

    rsa_pkg::rsa_snap_t              snap_reg;
    logic [rsa_pkg::SUM_W-1:0]       mag_reg;
    logic                            neg_reg;
    logic [rsa_pkg::STEP_W-1:0]      step_reg;
    logic                            last;
    logic                            out_free;

    logic [rsa_pkg::MUL_W-1:0]       mul_a_reg, acc_reg, acc_next, p_reg;
    logic [rsa_pkg::SUM_W-1:0]       mul_b_reg;
    logic [rsa_pkg::MUL_W:0]         diff;
    logic [rsa_pkg::DNUM_W-1:0]      dnum_reg;
    logic                            dneg_reg;

    logic [rsa_pkg::NUM_W-1:0]       num_reg;
    logic [rsa_pkg::DEN_W-1:0]       den_reg;
    logic [rsa_pkg::DEN_W:0]         rem_reg, rem_sh, rem_next;
    logic [rsa_pkg::QUO_W-1:0]       quo_reg, quo_next;
    logic                            q_ge;
    logic [rsa_pkg::QUO_W-1:0]       vq_reg;

    logic [rsa_pkg::QUO_W-1:0]       x_reg, res_reg, bit_reg, trial, res_next;
    logic                            s_ge;
    logic [rsa_pkg::QUO_W-1:0]       dev_reg;

    logic [rsa_pkg::SUM_W-1:0]       q_mag;
    logic                            m_valid_reg;

    always_comb begin
        q_mag = q_data.total[rsa_pkg::SUM_W-1] ? rsa_pkg::SUM_W'(-q_data.total)
                                               : rsa_pkg::SUM_W'(q_data.total);
        acc_next = acc_reg + (mul_b_reg[0] ? mul_a_reg : '0);
        diff     = {1'b0, p_reg} - {1'b0, acc_next};
        rem_sh   = {rem_reg[rsa_pkg::DEN_W-1:0], num_reg[rsa_pkg::NUM_W-1]};
        q_ge     = rem_sh >= {1'b0, den_reg};
        rem_next = q_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
        quo_next = {quo_reg[rsa_pkg::QUO_W-2:0], q_ge};
        trial    = res_reg + bit_reg;
        s_ge     = x_reg >= trial;
        res_next = s_ge ? (res_reg >> 1) + bit_reg : res_reg >> 1;
        out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        last       = 1'b0;
        unique case (state_reg)
            rsa_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    state_next = rsa_pkg::ST_MUL_P;
                end
            end
            rsa_pkg::ST_MUL_P: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::MUL_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_MUL_Q;
            end
            rsa_pkg::ST_MUL_Q: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::MUL_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_MUL_D;
            end
            rsa_pkg::ST_MUL_D: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::MUL_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_DIV_VAR;
            end
            rsa_pkg::ST_DIV_VAR: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::DIV_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_SQRT;
            end
            rsa_pkg::ST_SQRT: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::SQRT_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_DIV_MEAN;
            end
            rsa_pkg::ST_DIV_MEAN: begin
                last = step_reg == rsa_pkg::STEP_W'(rsa_pkg::DIV_STEPS - 1);
                if (last) state_next = rsa_pkg::ST_DONE;
            end
            rsa_pkg::ST_DONE: begin
                if (out_free) state_next = rsa_pkg::ST_IDLE;
            end
            default: state_next = rsa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsa_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= (last || state_reg == rsa_pkg::ST_IDLE) ? '0
                                                                 : step_reg + 1'b1;
            if (state_reg == rsa_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            rsa_pkg::ST_IDLE: begin
                snap_reg  <= q_data;
                mag_reg   <= q_mag;
                neg_reg   <= q_data.total[rsa_pkg::SUM_W-1];
                mul_a_reg <= rsa_pkg::MUL_W'(q_data.sq_sum);
                mul_b_reg <= rsa_pkg::SUM_W'(q_data.count);
                acc_reg   <= '0;
            end
            rsa_pkg::ST_MUL_P, rsa_pkg::ST_MUL_Q, rsa_pkg::ST_MUL_D: begin
                acc_reg   <= acc_next;
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
                if (last) begin
                    acc_reg <= '0;
                    if (state_reg == rsa_pkg::ST_MUL_P) begin
                        p_reg     <= acc_next;
                        mul_a_reg <= rsa_pkg::MUL_W'(mag_reg);
                        mul_b_reg <= mag_reg;
                    end else if (state_reg == rsa_pkg::ST_MUL_Q) begin
                        dnum_reg  <= diff[rsa_pkg::DNUM_W-1:0];
                        dneg_reg  <= diff[rsa_pkg::MUL_W];
                        mul_a_reg <= rsa_pkg::MUL_W'(snap_reg.count - 1'b1);
                        mul_b_reg <= rsa_pkg::SUM_W'(snap_reg.count);
                    end else begin
                        den_reg <= acc_next[rsa_pkg::DEN_W-1:0];
                        num_reg <= {dnum_reg, {(2 * rsa_pkg::FRAC_W){1'b0}}};
                        rem_reg <= '0;
                        quo_reg <= '0;
                    end
                end
            end
            rsa_pkg::ST_DIV_VAR, rsa_pkg::ST_DIV_MEAN: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                num_reg <= num_reg << 1;
                if (last && state_reg == rsa_pkg::ST_DIV_VAR) begin
                    vq_reg  <= quo_next;
                    x_reg   <= quo_next;
                    res_reg <= '0;
                    bit_reg <= rsa_pkg::QUO_W'(1) << (rsa_pkg::QUO_W - 2);
                end
            end
            rsa_pkg::ST_SQRT: begin
                if (s_ge) x_reg <= x_reg - trial;
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                if (last) begin
                    dev_reg <= res_next;
                    den_reg <= rsa_pkg::DEN_W'(snap_reg.count);
                    num_reg <= rsa_pkg::NUM_W'({mag_reg, {rsa_pkg::FRAC_W{1'b0}}});
                    rem_reg <= '0;
                    quo_reg <= '0;
                end
            end
            rsa_pkg::ST_DONE: begin
                if (out_free) begin
                    m_count   <= snap_reg.count;
                    m_total   <= snap_reg.total;
                    m_lowest  <= snap_reg.lowest;
                    m_highest <= snap_reg.highest;
                    if (snap_reg.count == '0) begin
                        m_mean_q16 <= '0;
                    end else begin
                        m_mean_q16 <= neg_reg ? -quo_reg[rsa_pkg::MEAN_W-1:0]
                                              : quo_reg[rsa_pkg::MEAN_W-1:0];
                    end
                    if (snap_reg.count > rsa_pkg::CNT_W'(1) && !dneg_reg) begin
                        m_variance_q16  <= vq_reg[rsa_pkg::VAR_W+rsa_pkg::FRAC_W-1:
                                                  rsa_pkg::FRAC_W];
                        m_deviation_q16 <= (dev_reg[rsa_pkg::QUO_W-1:rsa_pkg::DEV_W] != '0)
                                           ? {rsa_pkg::DEV_W{1'b1}}
                                           : dev_reg[rsa_pkg::DEV_W-1:0];
                    end else begin
                        m_variance_q16  <= '0;
                        m_deviation_q16 <= '0;
                    end
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == rsa_pkg::ST_MUL_P)) else $error("bad pop");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rsa_pkg::ST_DONE && !out_free) |=> $stable(m_count))
        else $error("result overwritten");
`endif

endmodule

@@ rtl/core/running_statistics_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// running_statistics_accumulator_core
// Cumulative count, sum, min, max, mean, variance and deviation of samples.
// ----------------------------------------------------------------------------
// Input channel s_*: one sample word per cycle; s_has_sample marks a real
// sample, s_group_end asks for a result after this word. Output channel m_*:
// one result word per group end, all values cumulative since reset.
// Samples are taken at one per cycle while s_ready is high; accumulation
// finishes in the cycle of acceptance. A group-end word pushes a snapshot
// into a two-entry queue; the result engine works through each snapshot in
// turn (three 36-step shift-add multiplies, two 104-step restoring divides,
// one 32-step square root), so s_ready drops only while the queue holds two
// pending snapshots.
// The result register holds its word while m_ready is low; the engine keeps
// working on the next snapshot behind it.
// Synchronous active-low reset clears all accumulators, the queue and m_valid.
// ----------------------------------------------------------------------------
module running_statistics_accumulator_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_has_sample,
    input  logic                                s_group_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [rsa_pkg::CNT_W-1:0]    m_count,
    output logic signed [rsa_pkg::SUM_W-1:0]    m_total,
    output logic signed [rsa_pkg::SAMPLE_W-1:0] m_lowest,
    output logic signed [rsa_pkg::SAMPLE_W-1:0] m_highest,
    output logic signed [rsa_pkg::MEAN_W-1:0]   m_mean_q16,
    output logic        [rsa_pkg::VAR_W-1:0]    m_variance_q16,
    output logic        [rsa_pkg::DEV_W-1:0]    m_deviation_q16
);

    logic               take, push, pop, q_full, q_empty;
    rsa_pkg::rsa_snap_t push_data, pop_data;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    rsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take       (take),
        .sample     (s_sample),
        .has_sample (s_has_sample),
        .group_end  (s_group_end),
        .push       (push),
        .push_data  (push_data)
    );

    rsa_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    rsa_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_data          (pop_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_count         (m_count),
        .m_total         (m_total),
        .m_lowest        (m_lowest),
        .m_highest       (m_highest),
        .m_mean_q16      (m_mean_q16),
        .m_variance_q16  (m_variance_q16),
        .m_deviation_q16 (m_deviation_q16)
    );

endmodule

@@ sim/rsa_stats_monitor.sv @@
// ----------------------------------------------------------------------------
// rsa_stats_monitor
// Watches both channels of the accumulator, predicts each statistics word
// from the accepted sample words and compares it field by field.
// ----------------------------------------------------------------------------
module rsa_stats_monitor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] s_sample,
    input  logic                                s_has_sample,
    input  logic                                s_group_end,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic        [rsa_pkg::CNT_W-1:0]    m_count,
    input  logic signed [rsa_pkg::SUM_W-1:0]    m_total,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] m_lowest,
    input  logic signed [rsa_pkg::SAMPLE_W-1:0] m_highest,
    input  logic signed [rsa_pkg::MEAN_W-1:0]   m_mean_q16,
    input  logic        [rsa_pkg::VAR_W-1:0]    m_variance_q16,
    input  logic        [rsa_pkg::DEV_W-1:0]    m_deviation_q16,
    output int                                  errors,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        [rsa_pkg::CNT_W-1:0]    count;
        logic signed [rsa_pkg::SUM_W-1:0]    total;
        logic signed [rsa_pkg::SAMPLE_W-1:0] lowest;
        logic signed [rsa_pkg::SAMPLE_W-1:0] highest;
        logic signed [rsa_pkg::MEAN_W-1:0]   mean;
        logic        [rsa_pkg::VAR_W-1:0]    variance;
        logic        [rsa_pkg::DEV_W-1:0]    deviation;
    } stats_t;

    stats_t                              stats_due[$];
    logic        [63:0]                  n_seen;
    logic signed [63:0]                  sum_acc;
    logic        [63:0]                  sq_acc;
    logic signed [rsa_pkg::SAMPLE_W-1:0] min_acc;
    logic signed [rsa_pkg::SAMPLE_W-1:0] max_acc;
    logic                                any_seen;
    int                                  words_out;

    assign pending = stats_due.size();

    function automatic logic [63:0] root64(input logic [63:0] x);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = x;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic stats_t predict_stats();
        stats_t      r;
        logic [63:0] mag;
        logic [63:0] m;
        logic [63:0] vq;
        logic [63:0] dv;
        logic [127:0] p;
        logic [127:0] q;
        logic [127:0] d;
        logic [127:0] den;
        mag = sum_acc[63] ? 64'(-sum_acc) : 64'(sum_acc);
        m   = '0;
        vq  = '0;
        dv  = '0;
        if (n_seen > 0) begin
            m = (mag << 16) / n_seen;
            if (sum_acc[63]) m = -m;
        end
        if (n_seen > 1) begin
            p = 128'(n_seen) * 128'(sq_acc);
            q = 128'(mag) * 128'(mag);
            d = p - q;
            if (!d[127]) begin
                den = 128'(64'(n_seen * (n_seen - 1)));
                vq  = 64'((d << 32) / den);
                dv  = root64(vq);
                if (dv > 64'h7FFF_FFFF) dv = 64'h7FFF_FFFF;
            end
        end
        r.count     = n_seen[rsa_pkg::CNT_W-1:0];
        r.total     = sum_acc[rsa_pkg::SUM_W-1:0];
        r.lowest    = min_acc;
        r.highest   = max_acc;
        r.mean      = m[rsa_pkg::MEAN_W-1:0];
        r.variance  = vq[rsa_pkg::VAR_W+rsa_pkg::FRAC_W-1:rsa_pkg::FRAC_W];
        r.deviation = dv[rsa_pkg::DEV_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        errors++;
        $display("%0t: word %0d %s mismatch: got %0h want %0h",
                 $time, words_out, what, got, want);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            n_seen   = '0;
            sum_acc  = '0;
            sq_acc   = '0;
            min_acc  = '0;
            max_acc  = '0;
            any_seen = 1'b0;
            errors   = 0;
            stats_due.delete();
            words_out <= 0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_has_sample && n_seen < 64'(rsa_pkg::COUNT_MAX)) begin
                    n_seen   = n_seen + 1;
                    sum_acc  = sum_acc + 64'(s_sample);
                    sq_acc   = sq_acc + 64'(64'(s_sample) * 64'(s_sample));
                    if (!any_seen || s_sample < min_acc) min_acc = s_sample;
                    if (!any_seen || s_sample > max_acc) max_acc = s_sample;
                    any_seen = 1'b1;
                end
                if (s_group_end) stats_due.push_back(predict_stats());
            end
            if (m_valid && m_ready) begin
                if (stats_due.size() == 0) begin
                    report("unexpected word", 64'(m_count), 64'd0);
                end else begin
                    stats_t e;
                    e = stats_due.pop_front();
                    if (m_count !== e.count) report("count", 64'(m_count), 64'(e.count));
                    if (m_total !== e.total) report("total", 64'(m_total), 64'(e.total));
                    if (m_lowest !== e.lowest)
                        report("lowest", 64'(m_lowest), 64'(e.lowest));
                    if (m_highest !== e.highest)
                        report("highest", 64'(m_highest), 64'(e.highest));
                    if (m_mean_q16 !== e.mean)
                        report("mean", 64'(m_mean_q16), 64'(e.mean));
                    if (m_variance_q16 !== e.variance)
                        report("variance", 64'(m_variance_q16), 64'(e.variance));
                    if (m_deviation_q16 !== e.deviation)
                        report("deviation", 64'(m_deviation_q16), 64'(e.deviation));
                end
                words_out <= words_out + 1;
            end
        end
    end

endmodule

@@ sim/running_statistics_accumulator_core_tb.sv @@
// ----------------------------------------------------------------------------
// running_statistics_accumulator_core_tb
// Drives directed and random sample words with random gaps and result-side
// stalls, and reports the monitor's verdict.
// ----------------------------------------------------------------------------
module running_statistics_accumulator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_valid;
    logic                                s_ready;
    logic signed [rsa_pkg::SAMPLE_W-1:0] s_sample;
    logic                                s_has_sample;
    logic                                s_group_end;
    logic                                m_valid;
    logic                                m_ready;
    logic        [rsa_pkg::CNT_W-1:0]    m_count;
    logic signed [rsa_pkg::SUM_W-1:0]    m_total;
    logic signed [rsa_pkg::SAMPLE_W-1:0] m_lowest;
    logic signed [rsa_pkg::SAMPLE_W-1:0] m_highest;
    logic signed [rsa_pkg::MEAN_W-1:0]   m_mean_q16;
    logic        [rsa_pkg::VAR_W-1:0]    m_variance_q16;
    logic        [rsa_pkg::DEV_W-1:0]    m_deviation_q16;
    int                                  errors;
    int                                  pending;
    logic                                burst;
    int                                  stall_mode;

    running_statistics_accumulator_core u_top (.*);

    rsa_stats_monitor u_mon (.*);

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #100ms;
        $display("running_statistics_accumulator_core_tb: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(199) == 0) stall_mode <= $urandom_range(2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3) != 0);
                default: m_ready <= ($urandom_range(19) == 0);
            endcase
        end
    end

    task automatic send_word(input logic [15:0] smp, input logic has, input logic ge);
        int g;
        g = pick_gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_sample     <= smp;
        s_has_sample <= has;
        s_group_end  <= ge;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        int fed;
        logic has;
        logic ge;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample     = '0;
        s_has_sample = 1'b0;
        s_group_end  = 1'b0;
        burst        = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty result, single sample, extreme pair
        send_word(16'h1234, 1'b0, 1'b1);
        send_word(16'h8000, 1'b1, 1'b1);
        send_word(16'h7FFF, 1'b1, 1'b1);
        send_word(16'hFFFF, 1'b0, 1'b0);
        send_word(16'h0000, 1'b1, 1'b0);
        send_word(16'hFFFF, 1'b1, 1'b1);
        send_word(16'h0001, 1'b1, 1'b0);
        send_word(16'h5555, 1'b1, 1'b0);
        send_word(16'hAAAA, 1'b1, 1'b1);
        send_word(16'h0000, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++) send_word(16'h7FFF, 1'b1, i == 5);
        for (int i = 0; i < 6; i++) send_word(16'h8000, 1'b1, i == 5);

        fed = 0;
        while (fed < 1578) begin
            if ($urandom_range(99) == 0) burst = ~burst;
            has = ($urandom_range(99) < 85);
            ge  = ($urandom_range(24) == 0);
            send_word(16'($urandom), has, ge);
            fed++;
        end
        send_word(16'h0000, 1'b0, 1'b1);
        s_valid <= 1'b0;
        drain();

        if (errors == 0) begin
            $display("running_statistics_accumulator_core_tb: clean");
        end else begin
            $display("running_statistics_accumulator_core_tb: errors");
        end
        $finish;
    end

endmodule
